// ===== rtl/pit_pkg.sv =====
// Package for the pre-integration table engine: beat types, memory entry layout,
// divider request and response, state encoding, constants and small helper functions.
// It has no dependencies. Both rtl/pit_div.sv and the top level import it.
package pit_pkg;

  // Table geometry and datapath widths.
  localparam int MaxEntries = 256;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int ChW        = 16;
  localparam int SumW       = 32;
  localparam int PixW       = 8;
  localparam int DistW      = 24;
  localparam int CntW       = 9;
  localparam int NW         = DistW + SumW;
  localparam int RemW       = NW + 8;

  // Divider modes: colour needs an 8-bit quotient over a 2^32 scale, opacity a 22-bit Q16 one.
  localparam int ColW     = 8;
  localparam int ColShift = 32;
  localparam int OpaW     = 22;
  localparam int OpaShift = 16;
  localparam int DshW     = IdxW + ColShift + ColW;
  localparam int StepW    = $clog2(OpaW + 1);

  // Configuration register indexes.
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 24;
  localparam logic [CfgIdxW-1:0] CfgEntryCount = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSampleDist = 1'b1;

  // Operation codes.
  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  // Exponent constants.
  localparam logic [16:0]     Log2eQ16 = 17'd94548;
  localparam logic [OpaW-1:0] XSat     = 22'h200000;
  localparam logic [16:0]     OneQ16   = 17'd65536;

  typedef struct packed {
    logic          opcode;
    logic [7:0]    index_a;
    logic [7:0]    index_b;
    logic [15:0]   red_in;
    logic [15:0]   green_in;
    logic [15:0]   blue_in;
    logic [15:0]   alpha_in;
  } pit_in_t;

  typedef struct packed {
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [7:0]  alpha_out;
    logic        bad_index;
  } pit_out_t;

  // One table entry: prefix sums and the raw sample; channel 0 is red.
  typedef struct packed {
    logic [3:0][SumW-1:0] sum;
    logic [3:0][ChW-1:0]  raw;
  } pit_entry_t;

  typedef struct packed {
    logic            start;
    logic            opacity;
    logic [RemW-1:0] num;
    logic [IdxW-1:0] den;
  } pit_div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic            sat;
    logic [OpaW-1:0] quo;
  } pit_div_rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StRdA,
    StRdB,
    StMul,
    StDivGo,
    StDivWait,
    StExp1,
    StExp2,
    StExp3,
    StFin
  } pit_state_e;

  // 2^(-i/16) in Q16 for i = 0..16.
  function automatic logic [16:0] pow2_neg(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

  // Q0.16 sample times 255, truncated to 8 bits.
  function automatic logic [PixW-1:0] raw_scale(input logic [ChW-1:0] s);
    logic [23:0] p;
    p = {s, 8'b0} - {8'b0, s};
    return p[23:16];
  endfunction

endpackage

// ===== rtl/preintegration_table_engine_top.sv =====
// Sequencing: a load gives no result. A flagged query goes from idle straight to the result
// stage, and an equal-index query after one table read. Other queries make two table reads,
// then for each colour channel and for opacity a multiply, the divider start and its wait (one
// quotient bit a cycle), then the exponent states StExp1 to StExp3 and the result stage.
// Throughput: one item at a time; a query blocks input until it reaches the output register.
// Reset: asynchronous, active low; restores control registers and running sums, not table memory.
module preintegration_table_engine_top
  import pit_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pit_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pit_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  pit_state_e state_q, state_d;

  logic [CntW-1:0]       entry_count_q;
  logic [DistW-1:0]      dist_q;
  logic [3:0][SumW-1:0]  run_q, run_d;
  logic [3:0][ChW-1:0]   smp;
  pit_entry_t            mem [MaxEntries];
  pit_entry_t            rdata_q;
  logic                  mem_we, mem_re;
  logic [IdxW-1:0]       rd_addr;

  logic                  in_acc, out_free, bad;
  logic [7:0]            a_q, b_q;
  logic                  bad_q;
  logic [3:0][SumW-1:0]  suma_q, sumb_q;
  logic [1:0]            ch_q;
  logic [NW-1:0]         n_q;
  logic [OpaW-1:0]       x_q;
  logic [22:0]           y_q;
  logic [16:0]           t0_q;
  logic [27:0]           prod_q;
  logic [6:0]            ip_q;
  logic [3:0][PixW-1:0]  px_q;
  logic                  out_valid_q;
  pit_out_t              out_q;

  pit_div_req_t          div_req;
  pit_div_rsp_t          div_rsp;

  // Combinational datapath terms.
  logic [SumW:0]         diff;
  logic [SumW-1:0]       mag;
  logic                  pos;
  logic [IdxW-1:0]       dmag;
  logic [RemW-1:0]       n_ext;
  logic [38:0]           y_full;
  logic [16:0]           t0, t1, tdiff;
  logic [16:0]           v, e, om;
  logic [24:0]           ap;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign bad      = ({1'b0, in_data_i.index_a} >= entry_count_q) ||
                    ({1'b0, in_data_i.index_b} >= entry_count_q);

  assign smp[0] = in_data_i.red_in;
  assign smp[1] = in_data_i.green_in;
  assign smp[2] = in_data_i.blue_in;
  assign smp[3] = in_data_i.alpha_in;

  // Running sums: a load at index zero starts them over.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      run_d[k] = ((in_data_i.index_a == 8'd0) ? '0 : run_q[k]) + SumW'(smp[k]);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc && in_data_i.opcode == OpQuery) begin
          state_d = bad ? StFin : StRdA;
        end
      end
      StRdA:     state_d = (a_q == b_q) ? StFin : StRdB;
      StRdB:     state_d = StMul;
      StMul:     state_d = StDivGo;
      StDivGo:   state_d = StDivWait;
      StDivWait: begin
        if (div_rsp.done) begin
          state_d = (ch_q == 2'd3) ? StExp1 : StMul;
        end
      end
      StExp1:    state_d = StExp2;
      StExp2:    state_d = StExp3;
      StExp3:    state_d = StFin;
      StFin: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default:   state_d = StIdle;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall_o = 1'b1;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    rd_addr    = in_data_i.index_a[IdxW-1:0];
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        mem_we     = in_valid_i && in_data_i.opcode == OpLoad;
        mem_re     = in_valid_i && in_data_i.opcode == OpQuery;
      end
      StRdA: begin
        mem_re  = 1'b1;
        rd_addr = b_q[IdxW-1:0];
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Table memory: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[in_data_i.index_a[IdxW-1:0]] <= '{sum: run_d, raw: smp};
    end
    if (mem_re) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Channel term: the sign test, the index distance and the scaled numerator.
  always_comb begin
    diff = {1'b0, suma_q[ch_q]} - {1'b0, sumb_q[ch_q]};
    mag  = diff[SumW] ? SumW'(-diff) : diff[SumW-1:0];
    pos  = (diff != '0) && (diff[SumW] == (a_q < b_q));
    dmag = (a_q > b_q) ? IdxW'(a_q - b_q) : IdxW'(b_q - a_q);
    n_ext = (ch_q == 2'd3) ? RemW'(n_q) : ({n_q, 8'b0} - RemW'(n_q));
  end

  assign div_req.start   = state_q == StDivGo;
  assign div_req.opacity = ch_q == 2'd3;
  assign div_req.num     = n_ext;
  assign div_req.den     = dmag;

  pit_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Exponent: 2^-y through the table, then the opacity scaling.
  always_comb begin
    y_full = 39'(x_q) * 39'(Log2eQ16);
    t0     = pow2_neg({1'b0, y_q[15:12]});
    t1     = pow2_neg(5'({1'b0, y_q[15:12]} + 5'd1));
    tdiff  = t0 - t1;
    v      = t0_q - 17'(prod_q >> 12);
    e      = (ip_q >= 7'd32) ? 17'd0 : (v >> ip_q[4:0]);
    om     = OneQ16 - e;
    ap     = {om, 8'b0} - 25'(om);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      entry_count_q <= CntW'(MaxEntries);
      dist_q        <= DistW'(65536);
      run_q         <= '0;
      ch_q          <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_index_i == CfgEntryCount) begin
        entry_count_q <= cfg_data_i[CntW-1:0];
      end
      if (cfg_we_i && cfg_index_i == CfgSampleDist) begin
        dist_q <= cfg_data_i[DistW-1:0];
      end
      if (in_acc && in_data_i.opcode == OpLoad) begin
        run_q <= run_d;
      end
      if (state_q == StRdB) begin
        ch_q <= '0;
      end else if (state_q == StDivWait && div_rsp.done && ch_q != 2'd3) begin
        ch_q <= ch_q + 2'd1;
      end
      if (state_q == StFin && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        a_q   <= in_data_i.index_a;
        b_q   <= in_data_i.index_b;
        bad_q <= bad;
        px_q  <= '0;
      end
      StRdA: begin
        suma_q <= rdata_q.sum;
        for (int k = 0; k < 4; k++) begin
          px_q[k] <= raw_scale(rdata_q.raw[k]);
        end
      end
      StRdB: begin
        sumb_q <= rdata_q.sum;
      end
      StMul: begin
        n_q <= pos ? NW'(dist_q) * NW'(mag) : '0;
      end
      StDivWait: begin
        if (div_rsp.done) begin
          px_q[ch_q] <= div_rsp.sat ? 8'hff : div_rsp.quo[PixW-1:0];
          x_q        <= (div_rsp.sat || div_rsp.quo > XSat) ? XSat : div_rsp.quo;
        end
      end
      StExp1: begin
        y_q <= y_full[38:16];
      end
      StExp2: begin
        t0_q   <= t0;
        prod_q <= 28'(tdiff[15:0]) * 28'(y_q[11:0]);
        ip_q   <= y_q[22:16];
      end
      StExp3: begin
        px_q[3] <= ap[23:16];
      end
      StFin: begin
        if (out_free) begin
          out_q.red_out   <= px_q[0];
          out_q.green_out <= px_q[1];
          out_q.blue_out  <= px_q[2];
          out_q.alpha_out <= px_q[3];
          out_q.bad_index <= bad_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A flagged query goes straight to the result stage.
  a_bad_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.opcode == OpQuery && bad |=> state_q == StFin)
    else $error("bad query did not skip the table read");

  // A finished pixel moves to the output register when it is free.
  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFin && out_free |=> out_valid_o && state_q == StIdle)
    else $error("finished pixel was not delivered");

  // The divider only runs while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> state_q == StDivWait)
    else $error("divider busy outside its wait state");

  // A flagged pixel carries zero colour.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_index |->
      out_data_o.red_out == 8'd0 && out_data_o.green_out == 8'd0 &&
      out_data_o.blue_out == 8'd0 && out_data_o.alpha_out == 8'd0)
    else $error("flagged pixel is not zero");

endmodule

// ===== rtl/pit_div.sv =====
// Sequential restoring divider that serves the colour and opacity terms, one quotient bit a cycle.
// It depends on pit_pkg for the request and response structs and for the mode widths.
module pit_div
  import pit_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  pit_div_req_t req_i,
  output pit_div_rsp_t rsp_o
);

  logic [RemW-1:0]  rem_q, rem_d;
  logic [DshW-1:0]  dsh_q, dsh_d;
  logic [OpaW-1:0]  quo_q, quo_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             sat_q, sat_d;
  logic [DshW-1:0]  den_ext;
  logic [DshW-1:0]  lim;
  logic             ge;

  assign den_ext = DshW'(req_i.den);
  assign lim     = req_i.opacity ? (den_ext << (OpaShift + OpaW))
                                 : (den_ext << (ColShift + ColW));
  assign ge      = rem_q >= RemW'(dsh_q);

  // Load on start, then one compare and subtract per cycle.
  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    sat_d  = sat_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.num;
      dsh_d  = req_i.opacity ? (den_ext << (OpaShift + OpaW - 1))
                             : (den_ext << (ColShift + ColW - 1));
      quo_d  = '0;
      cnt_d  = req_i.opacity ? StepW'(OpaW) : StepW'(ColW);
      sat_d  = req_i.num >= RemW'(lim);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - RemW'(dsh_q);
      end
      quo_d = {quo_q[OpaW-2:0], ge};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - StepW'(1);
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
    sat_q <= sat_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.sat  = sat_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ===== tb/preintegration_table_engine_top_test.sv =====
// Self-checking testbench for the pre-integration table engine: loads, queries and register writes,
// each pixel checked against an in-bench prediction of the table arithmetic.
// Depends on rtl/pit_pkg.sv and rtl/preintegration_table_engine_top.sv.
module preintegration_table_engine_top_test;
  import pit_pkg::*;

  localparam int InW = $bits(pit_in_t);

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  pit_in_t             in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  pit_out_t            out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  preintegration_table_engine_top u_dut (.*);

  // Predictor state.
  logic [8:0]      pr_count;
  logic [23:0]     pr_dist;
  logic [3:0][15:0] pr_raw [MaxEntries];
  longint          pr_sum [MaxEntries][4];
  longint          pr_run [4];

  pit_out_t pixel_queue[$];
  int       errors;
  int       queries_done;
  int       loads_sent;
  bit       hold_off;

  localparam int Pow2Tab [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                                  46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219,
                                  32768};

  // Colour channel: floor(255 * dist * diff / (den * 2^32)), clamped.
  function automatic logic [7:0] colour_of(longint diff, longint den);
    longint num;
    longint q;
    num = longint'(pr_dist) * diff;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num <= 0) return 8'd0;
    // 255*num fits in 64 bits: num < 2^24 * 2^24.
    q = (255 * num) / (den <<< 32);
    return q > 255 ? 8'd255 : q[7:0];
  endfunction

  // Opacity channel through the base-2 exponent approximation.
  function automatic logic [7:0] opacity_of(longint diff, longint den);
    longint num, x, y, ip, fp, v, e;
    int idx, fr;
    num = longint'(pr_dist) * diff;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num <= 0) return 8'd0;
    x = num / (den <<< 16);
    if (x > (32 <<< 16)) x = 32 <<< 16;
    y = (x * 94548) >>> 16;
    ip = y >>> 16;
    fp = y & 16'hffff;
    idx = int'(fp >>> 12);
    fr = int'(fp & 12'hfff);
    v = Pow2Tab[idx] - ((longint'(Pow2Tab[idx] - Pow2Tab[idx+1]) * fr) >>> 12);
    e = ip >= 32 ? 0 : (v >>> ip);
    return 8'(((65536 - e) * 255) >>> 16);
  endfunction

  function automatic logic [7:0] scale_raw(logic [15:0] s);
    return 8'((32'(s) * 255) >> 16);
  endfunction

  // Apply one accepted beat to the predictor; queue the pixel it causes.
  task automatic predict_pixel(pit_in_t it);
    pit_out_t px;
    int a, b, lim;
    a = int'(it.index_a);
    b = int'(it.index_b);
    if (it.opcode == OpLoad) begin
      if (a == 0) pr_run = '{0, 0, 0, 0};
      pr_run[0] += it.red_in;
      pr_run[1] += it.green_in;
      pr_run[2] += it.blue_in;
      pr_run[3] += it.alpha_in;
      pr_raw[a] = {it.alpha_in, it.blue_in, it.green_in, it.red_in};
      for (int k = 0; k < 4; k++) pr_sum[a][k] = pr_run[k];
      return;
    end
    lim = pr_count < MaxEntries ? pr_count : MaxEntries;
    px = '0;
    if (a >= lim || b >= lim) begin
      px.bad_index = 1'b1;
    end else if (a == b) begin
      px.red_out   = scale_raw(pr_raw[a][0]);
      px.green_out = scale_raw(pr_raw[a][1]);
      px.blue_out  = scale_raw(pr_raw[a][2]);
      px.alpha_out = scale_raw(pr_raw[a][3]);
    end else begin
      px.red_out   = colour_of(pr_sum[a][0] - pr_sum[b][0], a - b);
      px.green_out = colour_of(pr_sum[a][1] - pr_sum[b][1], a - b);
      px.blue_out  = colour_of(pr_sum[a][2] - pr_sum[b][2], a - b);
      px.alpha_out = opacity_of(pr_sum[a][3] - pr_sum[b][3], a - b);
    end
    pixel_queue.push_back(px);
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on run time.
  initial begin
    #20000000;
    $display("preintegration_table_engine_top_test failed");
    $finish;
  end

  // Predict at every accepted input beat.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) predict_pixel(in_data_i);
  end

  // Check every accepted output beat against the oldest expected pixel.
  always @(posedge clk_i) begin
    pit_out_t exp_px;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixel_queue.size() == 0) begin
        $error("unexpected pixel %h", out_data_o);
        errors++;
      end else begin
        exp_px = pixel_queue.pop_front();
        queries_done++;
        if (out_data_o.red_out !== exp_px.red_out) begin
          $error("red_out expected %0d got %0d", exp_px.red_out, out_data_o.red_out);
          errors++;
        end
        if (out_data_o.green_out !== exp_px.green_out) begin
          $error("green_out expected %0d got %0d", exp_px.green_out, out_data_o.green_out);
          errors++;
        end
        if (out_data_o.blue_out !== exp_px.blue_out) begin
          $error("blue_out expected %0d got %0d", exp_px.blue_out, out_data_o.blue_out);
          errors++;
        end
        if (out_data_o.alpha_out !== exp_px.alpha_out) begin
          $error("alpha_out expected %0d got %0d", exp_px.alpha_out, out_data_o.alpha_out);
          errors++;
        end
        if (out_data_o.bad_index !== exp_px.bad_index) begin
          $error("bad_index expected %0d got %0d", exp_px.bad_index, out_data_o.bad_index);
          errors++;
        end
      end
    end
  end

  // Receiver: random stall per beat, plus a long hold-off on request.
  initial begin
    int w;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        for (int i = 0; i < 400; i++) @(negedge clk_i);
        hold_off = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (w == 0) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b1;
        repeat (w) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Send one beat, after a random gap if gaps is set; wait for acceptance.
  task automatic send_beat(pit_in_t it, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 13) : 0;
    if (w > 0) begin
      in_valid_i <= 1'b0;
      repeat (w) @(negedge clk_i);
    end
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    if (it.opcode == OpLoad) loads_sent++;
  endtask

  task automatic load_beat(int idx, bit gaps, bit full = 0);
    pit_in_t it;
    it = InW'({$urandom, $urandom, $urandom});
    it.opcode = OpLoad;
    it.index_a = 8'(idx);
    if (full) begin
      it.red_in = 16'hffff;
      it.green_in = 16'hffff;
      it.blue_in = 16'hffff;
      it.alpha_in = 16'hffff;
    end
    send_beat(it, gaps);
  endtask

  // Query with both indices from written entries, or deliberately bad ones.
  task automatic query_beat(int a, int b, bit gaps);
    pit_in_t it;
    it = InW'({$urandom, $urandom, $urandom});
    it.opcode = OpQuery;
    it.index_a = 8'(a);
    it.index_b = 8'(b);
    send_beat(it, gaps);
  endtask

  // Drain, then pause for the slowest query before touching registers.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pixel_queue.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgEntryCount) pr_count = val[8:0];
    else pr_dist = val;
  endtask

  // Random query that only reads written entries, or is out of range.
  task automatic random_query(int filled, bit gaps);
    int a, b;
    a = $urandom_range(0, filled - 1);
    b = ($urandom_range(0, 3) == 0) ? a : $urandom_range(0, filled - 1);
    if ($urandom_range(0, 9) == 0) begin
      a = $urandom_range(pr_count < 256 ? pr_count : 255, 255);
      if (a < filled) a = $urandom_range(0, filled - 1);
    end
    query_beat(a, b, gaps);
  endtask

  typedef struct {
    bit          is_load;
    int          a;
    int          b;
    bit          full;
    bit          known;
    pit_out_t    px;
  } dir_row_t;

  dir_row_t dir_rows[$];

  // Stimulus.
  initial begin
    int filled;
    int items;
    errors = 0;
    queries_done = 0;
    loads_sent = 0;
    hold_off = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = CfgEntryCount;
    cfg_data_i = '0;
    pr_count = 9'd256;
    pr_dist = 24'd65536;
    pr_run = '{0, 0, 0, 0};
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table: extremes, equal indices and reversed order.
    dir_rows = '{
      '{1, 0, 0, 1, 0, '0}, '{1, 1, 0, 0, 0, '0}, '{1, 2, 0, 1, 0, '0},
      '{1, 255, 0, 1, 0, '0},
      '{0, 0, 0, 0, 1, '{8'd254, 8'd254, 8'd254, 8'd254, 1'b0}},
      '{0, 1, 1, 0, 0, '0}, '{0, 1, 0, 0, 0, '0}, '{0, 0, 1, 0, 0, '0},
      '{0, 2, 0, 0, 0, '0}, '{0, 0, 2, 0, 0, '0}, '{0, 255, 0, 0, 0, '0},
      '{0, 255, 255, 0, 1, '{8'd254, 8'd254, 8'd254, 8'd254, 1'b0}}
    };
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_load) load_beat(dir_rows[i].a, 0, dir_rows[i].full);
      else query_beat(dir_rows[i].a, dir_rows[i].b, 0);
    end
    drain;

    // Small table and the largest distance; then bad indices.
    write_reg(CfgEntryCount, 24'd2);
    write_reg(CfgSampleDist, 24'hffffff);
    query_beat(1, 0, 1);
    query_beat(0, 1, 1);
    query_beat(2, 0, 1);
    query_beat(0, 255, 1);
    drain;
    write_reg(CfgEntryCount, 24'd0);
    query_beat(0, 0, 1);
    drain;
    write_reg(CfgEntryCount, 24'd1);
    write_reg(CfgSampleDist, 24'd0);
    query_beat(0, 0, 1);
    query_beat(1, 0, 1);
    query_beat(0, 1, 1);
    drain;

    // Random phases: rebuild a table, then query it, under several settings.
    items = 0;
    for (int ph = 0; items < 1650; ph++) begin
      write_reg(CfgEntryCount, ph % 5 == 0 ? 24'd256 : 24'($urandom_range(1, 300)));
      write_reg(CfgSampleDist, ph % 4 == 0 ? 24'hffffff :
                ph % 4 == 1 ? 24'($urandom_range(0, 24'h3ffff)) : 24'($urandom));
      filled = $urandom_range(2, 40);
      for (int i = 0; i < filled; i++) begin
        load_beat(i, $urandom_range(0, 2) != 0, $urandom_range(0, 15) == 0);
        items++;
      end
      // Occasionally a broken rebuild: a few out-of-order reloads.
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < 3; i++) load_beat($urandom_range(1, filled - 1), 1);
        items += 3;
      end
      if (ph == 2) hold_off = 1;
      for (int i = 0; i < 30; i++) begin
        random_query(filled, (ph % 3) != 1);
        items++;
      end
      drain;
    end

    repeat (20) @(negedge clk_i);
    $display("Ran %0d loads and %0d checked queries over several table sizes and distances.",
             loads_sent, queries_done);
    if (errors == 0 && pixel_queue.size() == 0) begin
      $display("preintegration_table_engine_top_test passed");
    end else begin
      $display("preintegration_table_engine_top_test failed");
    end
    $finish;
  end

  // Directed rows with a hand-typed pixel are checked at the check point too.
  initial begin
    int qi;
    pit_out_t got;
    qi = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        while (qi < dir_rows.size() && dir_rows[qi].is_load) qi++;
        if (qi < dir_rows.size()) begin
          got = out_data_o;
          if (dir_rows[qi].known && got !== dir_rows[qi].px) begin
            $error("pixel expected %h got %h", dir_rows[qi].px, got);
            errors++;
          end
          qi++;
        end
      end
    end
  end

endmodule
